@@ design/fmms_pkg.sv @@
// shared constants and types for the min-max feature scaler
`default_nettype none
package fmms_pkg;
    localparam int VW      = 32;
    localparam int IW      = 7;
    localparam int MAXF    = 64;
    localparam int AW      = $clog2(MAXF);
    localparam int MW      = VW + 1;
    localparam int PW      = 2 * MW;
    localparam int QW      = VW + 2;
    localparam int CNTW    = $clog2(PW + 1);

    localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0] LOWER_RST = -(VW'(65536));
    localparam logic signed [VW-1:0] UPPER_RST = VW'(65536);
    localparam logic [IW-1:0] FIU_RST = IW'(MAXF);

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_LEARN = 2'd2,
        ACT_SCALE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        REG_LOWER = 2'd0,
        REG_UPPER = 2'd1,
        REG_FIU   = 2'd2,
        REG_NONE  = 2'd3
    } t_cfg_reg;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_SEL  = 10'b00_0000_0010,
        S_RD   = 10'b00_0000_0100,
        S_LOOK = 10'b00_0000_1000,
        S_MUL  = 10'b00_0001_0000,
        S_DIV  = 10'b00_0010_0000,
        S_SUM  = 10'b00_0100_0000,
        S_RES  = 10'b00_1000_0000,
        S_PUSH = 10'b01_0000_0000,
        S_FIN  = 10'b10_0000_0000
    } t_state;
endpackage
`default_nettype wire

@@ design/feature_minmax_scaler.sv @@
// min-max feature scaler: range table, sparse walk and serial divider
//
// Input beats carry one action: clear the range table, load one entry, learn
// from one sparse element or scale one sparse element. Skipped feature indices
// are visited as the value zero, and at the end of a vector the remaining
// indices up to features_in_use are filled the same way.
// Output beats are the nonzero scaled values of a scale beat; out_last marks
// the final result of that input beat. Other actions give no output beat.
// Clear and load complete on acceptance, with no busy state. Each visited
// index of learn passes through select, table read and update. Each visited
// index of scale that needs the general formula passes through multiply,
// the one-bit-per-cycle restoring divider over the 66-bit product, and sum;
// bound hits skip the arithmetic, a single-valued feature gives no result,
// and a held result is pushed in its own step. Learn and scale also have
// steps to accept and to finish, plus one to hand over the last result. One
// result is held back until the next is known, so out_last can be set.
// o_in_stall is high from acceptance until the last result has been handed to
// the output register. When the receiver stalls, the output register holds its
// beat and the sequencer waits before pushing the next one.
// Reset clears the table at once through per-entry valid bits, restores the
// default registers and leaves the block idle; the output is empty.
// Configuration may be written only while the block is idle.
`default_nettype none
module feature_minmax_scaler (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [1:0]                   i_cfg_index,
    input  wire logic [fmms_pkg::VW-1:0]      i_cfg_wdata,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [1:0]                   i_action,
    input  wire logic [fmms_pkg::IW-1:0]      i_feature_index,
    input  wire logic signed [fmms_pkg::VW-1:0] i_sample_value,
    input  wire logic signed [fmms_pkg::VW-1:0] i_range_low,
    input  wire logic signed [fmms_pkg::VW-1:0] i_range_high,
    input  wire logic                         i_last_of_vector,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [fmms_pkg::IW-1:0]           o_out_index,
    output logic signed [fmms_pkg::VW-1:0]    o_out_value,
    output logic                              o_out_last
);
    localparam int VW = fmms_pkg::VW;
    localparam int IW = fmms_pkg::IW;
    localparam int AW = fmms_pkg::AW;
    localparam int MW = fmms_pkg::MW;
    localparam int PW = fmms_pkg::PW;
    localparam int QW = fmms_pkg::QW;
    localparam int CW = fmms_pkg::CNTW;
    localparam int SW = QW + 2;

    fmms_pkg::t_state r_state;

    logic signed [VW-1:0] r_lower, r_upper;
    logic [IW-1:0]        r_fiu;
    logic [fmms_pkg::MAXF-1:0] r_valid;
    logic [IW-1:0]        r_next, r_cur, r_idx, r_vidx;
    logic signed [VW-1:0] r_v, r_vval;
    logic                 r_scale, r_last, r_ph_elem;

    logic [2*VW-1:0]      r_mem [fmms_pkg::MAXF];
    logic [2*VW-1:0]      r_rd;
    logic                 r_rdv;

    logic [MW-1:0]        r_ma, r_mb, r_den;
    logic                 r_neg, r_zero;
    logic [PW-1:0]        r_prod;
    logic [MW:0]          r_rem;
    logic [QW-1:0]        r_q;
    logic                 r_big;
    logic [CW-1:0]        r_cnt;
    logic signed [VW-1:0] r_res;

    logic                 r_hp;
    logic [IW-1:0]        r_pidx;
    logic signed [VW-1:0] r_pval;

    logic                 r_ov, r_olast;
    logic [IW-1:0]        r_oidx;
    logic signed [VW-1:0] r_oval;

    logic                 in_acc, out_free, push_now;
    logic [IW-1:0]        n_fill, in_idx;
    logic signed [VW-1:0] mn, mx, n_min, n_max;
    logic signed [MW-1:0] span, off, den;
    logic [MW:0]          trial;
    logic                 ge;
    logic signed [SW-1:0] n_sum;
    logic signed [VW-1:0] n_sat;
    logic                 w_we;
    logic [AW-1:0]        w_addr;
    logic [2*VW-1:0]      w_data;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_ov || !i_out_stall;
    assign push_now = (r_state == fmms_pkg::S_PUSH || r_state == fmms_pkg::S_FIN) && out_free;
    assign in_idx   = (i_feature_index > IW'(fmms_pkg::MAXF)) ? '0 : i_feature_index;
    assign n_fill   = (r_fiu > IW'(fmms_pkg::MAXF)) ? IW'(fmms_pkg::MAXF) : r_fiu;

    assign mn = r_rdv ? $signed(r_rd[2*VW-1:VW]) : fmms_pkg::VAL_MAX;
    assign mx = r_rdv ? $signed(r_rd[VW-1:0])    : fmms_pkg::VAL_MIN;
    assign n_min = (r_vval < mn) ? r_vval : mn;
    assign n_max = (r_vval > mx) ? r_vval : mx;

    assign span = MW'(r_upper) - MW'(r_lower);
    assign off  = MW'(r_vval) - MW'(mn);
    assign den  = MW'(mx) - MW'(mn);

    assign trial = {r_rem[MW-1:0], r_prod[PW-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_comb begin
        logic signed [SW-1:0] q_ext;
        q_ext = r_zero ? '0 : $signed({2'b00, r_q});
        n_sum = r_neg ? (SW'(r_lower) - q_ext) : (SW'(r_lower) + q_ext);
        if (r_big && !r_zero) begin
            n_sat = r_neg ? fmms_pkg::VAL_MIN : fmms_pkg::VAL_MAX;
        end else if (n_sum > SW'(fmms_pkg::VAL_MAX)) begin
            n_sat = fmms_pkg::VAL_MAX;
        end else if (n_sum < SW'(fmms_pkg::VAL_MIN)) begin
            n_sat = fmms_pkg::VAL_MIN;
        end else begin
            n_sat = n_sum[VW-1:0];
        end
    end

    always_comb begin
        w_we   = 1'b0;
        w_addr = AW'(r_vidx - IW'(1));
        w_data = {n_min, n_max};
        if (in_acc && i_action == fmms_pkg::ACT_LOAD) begin
            w_we   = (i_feature_index != '0) && (i_feature_index <= IW'(fmms_pkg::MAXF));
            w_addr = AW'(i_feature_index - IW'(1));
            w_data = {i_range_low, i_range_high};
        end else if (r_state == fmms_pkg::S_LOOK && !r_scale) begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_data;
        end
        if (r_state == fmms_pkg::S_RD) begin
            r_rd <= r_mem[AW'(r_vidx - IW'(1))];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fmms_pkg::S_IDLE;
            r_lower <= fmms_pkg::LOWER_RST;
            r_upper <= fmms_pkg::UPPER_RST;
            r_fiu   <= fmms_pkg::FIU_RST;
            r_valid <= '0;
            r_next  <= IW'(1);
            r_hp    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && !i_out_stall && !push_now) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (fmms_pkg::t_cfg_reg'(i_cfg_index))
                    fmms_pkg::REG_LOWER: r_lower <= i_cfg_wdata;
                    fmms_pkg::REG_UPPER: r_upper <= i_cfg_wdata;
                    fmms_pkg::REG_FIU:   r_fiu   <= i_cfg_wdata[IW-1:0];
                    fmms_pkg::REG_NONE:  ;
                endcase
            end
            if (w_we) begin
                r_valid[w_addr] <= 1'b1;
            end
            unique case (r_state)
                fmms_pkg::S_IDLE: begin
                    if (in_acc) begin
                        r_scale   <= i_action == fmms_pkg::ACT_SCALE;
                        r_last    <= i_last_of_vector;
                        r_idx     <= in_idx;
                        r_v       <= i_sample_value;
                        r_cur     <= r_next;
                        r_ph_elem <= in_idx != '0;
                        unique case (fmms_pkg::t_action'(i_action))
                            fmms_pkg::ACT_CLEAR: begin
                                r_valid <= '0;
                                r_next  <= IW'(1);
                            end
                            fmms_pkg::ACT_LOAD: ;
                            fmms_pkg::ACT_LEARN,
                            fmms_pkg::ACT_SCALE: r_state <= fmms_pkg::S_SEL;
                        endcase
                    end
                end
                fmms_pkg::S_SEL: begin
                    if (r_ph_elem) begin
                        if (r_cur < r_idx) begin
                            r_vidx <= r_cur;
                            r_vval <= '0;
                            r_cur  <= r_cur + IW'(1);
                        end else begin
                            r_vidx    <= r_idx;
                            r_vval    <= r_v;
                            r_cur     <= r_idx + IW'(1);
                            r_next    <= r_idx + IW'(1);
                            r_ph_elem <= 1'b0;
                        end
                        r_state <= fmms_pkg::S_RD;
                    end else if (r_last && r_cur <= n_fill) begin
                        r_vidx  <= r_cur;
                        r_vval  <= '0;
                        r_cur   <= r_cur + IW'(1);
                        r_state <= fmms_pkg::S_RD;
                    end else begin
                        if (r_last) begin
                            r_next <= IW'(1);
                        end
                        r_state <= r_hp ? fmms_pkg::S_FIN : fmms_pkg::S_IDLE;
                    end
                end
                fmms_pkg::S_RD: begin
                    r_rdv   <= r_valid[AW'(r_vidx - IW'(1))];
                    r_state <= fmms_pkg::S_LOOK;
                end
                fmms_pkg::S_LOOK: begin
                    r_ma   <= span[MW-1] ? MW'(-span) : MW'(span);
                    r_mb   <= off[MW-1]  ? MW'(-off)  : MW'(off);
                    r_den  <= den[MW-1]  ? MW'(-den)  : MW'(den);
                    r_neg  <= (span[MW-1] ^ off[MW-1]) ^ den[MW-1];
                    r_zero <= (span == '0) || (off == '0);
                    if (!r_scale || mx == mn) begin
                        r_state <= fmms_pkg::S_SEL;
                    end else if (r_vval == mn) begin
                        r_res   <= r_lower;
                        r_state <= fmms_pkg::S_RES;
                    end else if (r_vval == mx) begin
                        r_res   <= r_upper;
                        r_state <= fmms_pkg::S_RES;
                    end else begin
                        r_state <= fmms_pkg::S_MUL;
                    end
                end
                fmms_pkg::S_MUL: begin
                    r_prod  <= r_ma * r_mb;
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_big   <= 1'b0;
                    r_cnt   <= '0;
                    r_state <= fmms_pkg::S_DIV;
                end
                fmms_pkg::S_DIV: begin
                    r_prod <= {r_prod[PW-2:0], 1'b0};
                    r_rem  <= ge ? (trial - {1'b0, r_den}) : trial;
                    r_q    <= {r_q[QW-2:0], ge};
                    if (r_q[QW-1]) begin
                        r_big <= 1'b1;
                    end
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(PW - 1)) begin
                        r_state <= fmms_pkg::S_SUM;
                    end
                end
                fmms_pkg::S_SUM: begin
                    r_res   <= n_sat;
                    r_state <= fmms_pkg::S_RES;
                end
                fmms_pkg::S_RES: begin
                    if (r_res == '0) begin
                        r_state <= fmms_pkg::S_SEL;
                    end else if (r_hp) begin
                        r_state <= fmms_pkg::S_PUSH;
                    end else begin
                        r_hp    <= 1'b1;
                        r_pidx  <= r_vidx;
                        r_pval  <= r_res;
                        r_state <= fmms_pkg::S_SEL;
                    end
                end
                fmms_pkg::S_PUSH: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_oidx  <= r_pidx;
                        r_oval  <= r_pval;
                        r_olast <= 1'b0;
                        r_pidx  <= r_vidx;
                        r_pval  <= r_res;
                        r_state <= fmms_pkg::S_SEL;
                    end
                end
                fmms_pkg::S_FIN: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_oidx  <= r_pidx;
                        r_oval  <= r_pval;
                        r_olast <= 1'b1;
                        r_hp    <= 1'b0;
                        r_state <= fmms_pkg::S_IDLE;
                    end
                end
                default: r_state <= fmms_pkg::S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = r_state != fmms_pkg::S_IDLE;
    assign o_out_valid = r_ov;
    assign o_out_index = r_oidx;
    assign o_out_value = r_oval;
    assign o_out_last  = r_olast;
endmodule
`default_nettype wire

@@ design/fmms_checker.sv @@
// port-level checker for the min-max feature scaler, bound to the top level
`default_nettype none
module fmms_port_checks (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      o_in_stall,
    input wire logic                      o_out_valid,
    input wire logic                      i_out_stall,
    input wire logic [fmms_pkg::IW-1:0]   o_out_index,
    input wire logic [fmms_pkg::VW-1:0]   o_out_value,
    input wire logic                      o_out_last
);
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_value)
            && $stable(o_out_index) && $stable(o_out_last))
        else $error("stalled output beat changed");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_index != '0
            && o_out_index <= fmms_pkg::IW'(fmms_pkg::MAXF) && o_out_value != '0)
        else $error("output beat with bad index or zero value");

    a_busy_mid_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_last |-> o_in_stall)
        else $error("input taken before last result of beat");
endmodule

bind feature_minmax_scaler fmms_port_checks u_fmms_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_index (o_out_index),
    .o_out_value (o_out_value),
    .o_out_last  (o_out_last)
);
`default_nettype wire

@@ test/fmms_checker.sv @@
// checker for the min-max feature scaler: range table prediction and result comparison
module fmms_checker
    import fmms_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [VW-1:0]        i_cfg_wdata,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_stall,
    input  wire logic [1:0]           i_action,
    input  wire logic [IW-1:0]        i_feature_index,
    input  wire logic signed [VW-1:0] i_sample_value,
    input  wire logic signed [VW-1:0] i_range_low,
    input  wire logic signed [VW-1:0] i_range_high,
    input  wire logic                 i_last_of_vector,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_stall,
    input  wire logic [IW-1:0]        i_out_index,
    input  wire logic signed [VW-1:0] i_out_value,
    input  wire logic                 i_out_last,
    output int                        o_fail_count,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [IW-1:0]        idx;
        logic signed [VW-1:0] val;
        logic                 last;
    } t_scaled;

    t_scaled scaled_q[$];
    t_scaled batch_q[$];
    logic signed [VW-1:0] lower_bound;
    logic signed [VW-1:0] upper_bound;
    logic [IW-1:0]        fill_count;
    logic signed [VW-1:0] min_tab[MAXF];
    logic signed [VW-1:0] max_tab[MAXF];
    int                   next_idx;
    int                   fails;

    assign o_fail_count = fails;
    assign o_pending    = scaled_q.size();

    task automatic report_mismatch(input string msg);
        $display("[%0t] %s", $time, msg);
        fails++;
    endtask

    task automatic clear_ranges();
        for (int i = 0; i < MAXF; i++) begin
            min_tab[i] = VAL_MAX;
            max_tab[i] = VAL_MIN;
        end
        next_idx = 1;
    endtask

    function automatic longint magnitude(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    task automatic visit_feature(input bit do_scale, input int idx, input longint v);
        longint    mn;
        longint    mx;
        longint    span;
        longint    off;
        longint    den;
        longint    r;
        logic [127:0] q;
        bit        neg;
        t_scaled   res;
        mn = min_tab[idx-1];
        mx = max_tab[idx-1];
        if (!do_scale) begin
            if (v > mx) max_tab[idx-1] = v[VW-1:0];
            if (v < mn) min_tab[idx-1] = v[VW-1:0];
            return;
        end
        if (mx == mn) return;
        if (v == mn) begin
            r = lower_bound;
        end else if (v == mx) begin
            r = upper_bound;
        end else begin
            span = longint'(upper_bound) - longint'(lower_bound);
            off  = v - mn;
            den  = mx - mn;
            q = (128'(magnitude(span)) * 128'(magnitude(off))) / 128'(magnitude(den));
            if (q > (128'd1 << 62)) q = 128'd1 << 62;
            if (span == 0 || off == 0) q = 0;
            neg = ((span < 0) != (off < 0)) != (den < 0);
            r = neg ? longint'(lower_bound) - longint'(q[63:0])
                    : longint'(lower_bound) + longint'(q[63:0]);
            if (r > longint'(VAL_MAX)) r = VAL_MAX;
            if (r < longint'(VAL_MIN)) r = VAL_MIN;
        end
        if (r != 0 && batch_q.size() < MAXF) begin
            res.idx  = IW'(idx);
            res.val  = r[VW-1:0];
            res.last = 1'b0;
            batch_q.push_back(res);
        end
    endtask

    task automatic predict_beat();
        int idx;
        int fill;
        bit do_scale;
        t_scaled res;
        idx = i_feature_index;
        do_scale = (i_action == ACT_SCALE);
        batch_q.delete();
        case (t_action'(i_action))
            ACT_CLEAR: begin
                clear_ranges();
            end
            ACT_LOAD: begin
                if (idx >= 1 && idx <= MAXF) begin
                    min_tab[idx-1] = i_range_low;
                    max_tab[idx-1] = i_range_high;
                end
            end
            default: begin
                if (idx > MAXF) idx = 0;
                if (idx != 0) begin
                    for (int i = next_idx; i < idx; i++) visit_feature(do_scale, i, 0);
                    visit_feature(do_scale, idx, i_sample_value);
                    next_idx = idx + 1;
                end
                if (i_last_of_vector) begin
                    fill = (fill_count > MAXF) ? MAXF : fill_count;
                    for (int i = next_idx; i <= fill; i++) visit_feature(do_scale, i, 0);
                    next_idx = 1;
                end
            end
        endcase
        if (batch_q.size() > 0) batch_q[batch_q.size()-1].last = 1'b1;
        foreach (batch_q[i]) scaled_q.push_back(batch_q[i]);
    endtask

    always @(posedge i_clk) begin
        t_scaled want;
        if (!i_rst_n) begin
            lower_bound = LOWER_RST;
            upper_bound = UPPER_RST;
            fill_count  = FIU_RST;
            clear_ranges();
            scaled_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_LOWER: lower_bound = i_cfg_wdata;
                    REG_UPPER: upper_bound = i_cfg_wdata;
                    REG_FIU:   fill_count  = i_cfg_wdata[IW-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (scaled_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result beat index %0d value %0d",
                                              i_out_index, i_out_value));
                end else begin
                    want = scaled_q.pop_front();
                    if (i_out_index !== want.idx || i_out_value !== want.val
                            || i_out_last !== want.last)
                        report_mismatch($sformatf(
                            "result got idx %0d val %0d last %0b, want %0d %0d %0b",
                            i_out_index, i_out_value, i_out_last,
                            want.idx, want.val, want.last));
                end
            end
            if (i_in_valid && !i_in_stall) predict_beat();
        end
    end

    initial fails = 0;
endmodule

@@ test/tb_top.sv @@
// top of the min-max feature scaler testbench: clock, reset, stimulus and verdict
module tb_top;
    import fmms_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 60000;
    localparam int SETTLE_WAIT = 5000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [1:0]           i_cfg_index = '0;
    logic [VW-1:0]        i_cfg_wdata = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [1:0]           i_action = '0;
    logic [IW-1:0]        i_feature_index = '0;
    logic signed [VW-1:0] i_sample_value = '0;
    logic signed [VW-1:0] i_range_low = '0;
    logic signed [VW-1:0] i_range_high = '0;
    logic                 i_last_of_vector = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [IW-1:0]        o_out_index;
    logic signed [VW-1:0] o_out_value;
    logic                 o_out_last;
    int                   fail_count;
    int                   pending;
    int                   idle_cycles = 0;
    int                   sent = 0;
    int                   stall_left = 0;
    int                   stall_kind = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    feature_minmax_scaler dut (.*);

    fmms_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_wdata,
        .i_in_valid, .i_in_stall(o_in_stall), .i_action, .i_feature_index,
        .i_sample_value, .i_range_low, .i_range_high, .i_last_of_vector,
        .i_out_valid(o_out_valid), .i_out_stall, .i_out_index(o_out_index),
        .i_out_value(o_out_value), .i_out_last(o_out_last),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stall pattern: free stretches, random stalls, long holds
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_left <= $urandom_range(1, 60);
            stall_kind <= $urandom_range(0, 9);
        end else begin
            stall_left <= stall_left - 1;
        end
        i_out_stall <= (stall_kind < 3) ? 1'b0 :
                       (stall_kind == 9) ? 1'b1 : ($urandom_range(0, 3) == 0);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("feature_minmax_scaler: mismatch");
            $finish;
        end
    end

    task automatic send_beat(input t_action act, input int idx, input logic [VW-1:0] v,
                             input logic [VW-1:0] lo, input logic [VW-1:0] hi,
                             input bit last);
        int gap;
        int pick;
        pick = $urandom_range(0, 19);
        gap = (pick < 10) ? 0 : (pick < 18) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_action         <= act;
        i_feature_index  <= IW'(idx);
        i_sample_value   <= v;
        i_range_low      <= lo;
        i_range_high     <= hi;
        i_last_of_vector <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent++;
    endtask

    function automatic logic [VW-1:0] pick_value();
        logic [VW-1:0] v;
        case ($urandom_range(0, 6))
            0: v = '0;
            1: v = VW'(65536);
            2: v = VW'($urandom_range(0, 7)) << 16;
            3: v = $urandom;
            4: v = VW'($urandom_range(0, 255));
            5: v = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
            default: v = VW'($urandom_range(0, 3)) << 15;
        endcase
        if ($urandom_range(0, 1)) v = -v;
        return v;
    endfunction

    task automatic send_vector(input t_action act);
        int n;
        int idx;
        bit last;
        n = $urandom_range(1, 5);
        idx = 0;
        for (int k = 0; k < n; k++) begin
            last = (k == n - 1);
            idx += $urandom_range(1, 14);
            if (idx > MAXF) idx = $urandom_range(1, MAXF);
            if (last && $urandom_range(0, 7) == 0) idx = 0;
            send_beat(act, idx, pick_value(), $urandom, $urandom, last);
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg r, input logic [VW-1:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= r;
        i_cfg_wdata <= d;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_scaling(input logic [VW-1:0] lo, input logic [VW-1:0] hi,
                               input int fiu);
        settle();
        write_reg(REG_LOWER, lo);
        write_reg(REG_UPPER, hi);
        write_reg(REG_FIU, VW'(fiu));
    endtask

    task automatic random_phase(input int count);
        int stop;
        int pick;
        stop = sent + count;
        while (sent < stop) begin
            pick = $urandom_range(0, 19);
            if (pick < 8)
                send_vector(ACT_LEARN);
            else if (pick < 15)
                send_vector(ACT_SCALE);
            else if (pick < 17)
                send_beat(ACT_LOAD, $urandom_range(0, 127), $urandom, pick_value(),
                          pick_value(), $urandom_range(0, 1));
            else if (pick == 17)
                send_beat(ACT_CLEAR, $urandom_range(0, 127), $urandom, $urandom,
                          $urandom, $urandom_range(0, 1));
            else
                send_beat(t_action'($urandom_range(0, 3)), $urandom_range(0, 127),
                          $urandom, $urandom, $urandom, $urandom_range(0, 1));
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // never-learned ranges, whole vector filled
        send_beat(ACT_SCALE, 0, 0, 0, 0, 1'b1);
        send_beat(ACT_LOAD, 3, 0, VW'(65536), VW'(65536), 1'b0);
        send_beat(ACT_LOAD, 0, 0, VW'(5), VW'(9), 1'b0);
        send_beat(ACT_LOAD, 65, 0, VW'(5), VW'(9), 1'b0);
        send_beat(ACT_LOAD, 127, 0, VW'(5), VW'(9), 1'b0);
        send_beat(ACT_LOAD, 1, 0, -VW'(65536), VW'(65536), 1'b0);
        send_beat(ACT_SCALE, 1, -VW'(65536), 0, 0, 1'b0);
        send_beat(ACT_SCALE, 1, VW'(65536), 0, 0, 1'b0);
        send_beat(ACT_SCALE, 1, VW'(12345), 0, 0, 1'b1);
        send_beat(ACT_LEARN, 2, VAL_MAX, 0, 0, 1'b0);
        send_beat(ACT_LEARN, 2, VAL_MIN, 0, 0, 1'b0);
        send_beat(ACT_LEARN, 5, VW'(3 << 16), 0, 0, 1'b0);
        send_beat(ACT_LEARN, 100, 0, 0, 0, 1'b1);
        send_beat(ACT_SCALE, 2, VAL_MAX, 0, 0, 1'b0);
        send_beat(ACT_SCALE, 2, VW'(-7), 0, 0, 1'b0);
        send_beat(ACT_SCALE, 5, VW'(1 << 16), 0, 0, 1'b0);
        send_beat(ACT_SCALE, 3, VW'(65536), 0, 0, 1'b0);
        send_beat(ACT_SCALE, 64, VAL_MIN, 0, 0, 1'b1);
        send_beat(ACT_CLEAR, 0, 0, 0, 0, 1'b0);
        send_beat(ACT_SCALE, 5, VW'(1), 0, 0, 1'b1);

        set_scaling(VAL_MIN, VAL_MAX, 1);
        random_phase(40);
        set_scaling(VAL_MAX, VAL_MIN, 0);
        random_phase(35);
        set_scaling(0, 0, 64);
        random_phase(30);
        set_scaling(VW'(-3 << 16), VW'(5 << 16), 127);
        random_phase(35);
        set_scaling($urandom, $urandom, $urandom_range(0, 127));
        random_phase(35);
        set_scaling(LOWER_RST, UPPER_RST, $urandom_range(1, 20));
        random_phase(35);

        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("feature_minmax_scaler: match");
        else
            $display("feature_minmax_scaler: mismatch");
        $finish;
    end
endmodule
